FILE: sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 16;
	localparam int DATA_W       = 32;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
	localparam int NEED_W       = DATA_W + 2;

	localparam logic [DATA_W-1:0] HEAP_RESET = 32'd65536;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_AWALK,
		S_ALAST,
		S_ASHIFT,
		S_APLACE,
		S_FWALK,
		S_FSHIFT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] start;
		logic [DATA_W-1:0] length;
	} entry_t;

	typedef struct packed {
		logic [NEED_W-1:0] need;
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] grant;
		logic              fit;
		logic              match;
	} calc_t;

endpackage

FILE: sv/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba_req_if / ffba_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface ffba_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] request_size;
	logic [31:0] block_address;

	modport source (output valid, operation, request_size, block_address, input ready);
	modport sink (input valid, operation, request_size, block_address, output ready);
endinterface

interface ffba_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] granted_address;
	logic [1:0]  status;

	modport source (output valid, granted_address, status, input ready);
	modport sink (input valid, granted_address, status, output ready);
endinterface

FILE: sv/ffba_unit.sv
// ----------------------------------------------------------------------------
// ffba_unit
// Shared add/compare unit: block end sums, fit test and free address match.
// ----------------------------------------------------------------------------
module ffba_unit (
	input  ffba_pkg::entry_t                  ent,
	input  logic [ffba_pkg::DATA_W-1:0]       size,
	input  logic [ffba_pkg::DATA_W-1:0]       addr,
	input  logic [ffba_pkg::DATA_W-1:0]       limit,
	input  logic [ffba_pkg::DATA_W-1:0]       base_prev,
	input  logic [ffba_pkg::NEED_W-1:0]       need_prev,
	output ffba_pkg::calc_t                   calc
);
	import ffba_pkg::*;

	logic [DATA_W:0] base_w;
	logic [DATA_W:0] user_w;

	assign base_w = {1'b0, ent.start} + {1'b0, ent.length} + (DATA_W + 1)'(HEADER_BYTES);
	assign user_w = {1'b0, ent.start} + (DATA_W + 1)'(HEADER_BYTES);

	assign calc.need  = NEED_W'(ent.start) + NEED_W'(ent.length) + NEED_W'(size)
		+ NEED_W'(2 * HEADER_BYTES);
	assign calc.base  = base_w[DATA_W-1:0];
	assign calc.grant = base_prev + DATA_W'(HEADER_BYTES);
	assign calc.fit   = need_prev < NEED_W'(limit);
	assign calc.match = user_w == {1'b0, addr};

endmodule

FILE: sv/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// Address-ordered first-fit allocator over a sorted table of blocks.
//
//   channel  dir  handshake      word
//   req      in   valid/ready    operation, request_size, block_address
//   rsp      out  valid/ready    granted_address, status
//   cfg      in   cfg_we         cfg_wdata -> heap_size
//
// one word at a time; ready only while idle
// allocate: walks entries to the first fitting gap, moves the later entries up
// and writes the new one; past the last block it tests the heap end; full: no walk
// free: compares entries with the address, then moves the later entries down
// the single table read port sets one entry per cycle for walks and moves
// reset leaves only the base block; a stalled rsp holds the next result back
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	ffba_req_if.sink                      req,
	ffba_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [ffba_pkg::DATA_W-1:0]   cfg_wdata
);
	import ffba_pkg::*;

	state_t             state_q, state_nx;
	logic [DATA_W-1:0]  heap_q;
	logic [CNT_W-1:0]   count_q, idx_q, sh_q, pos_q;
	logic [NEED_W-1:0]  need_q;
	logic [DATA_W-1:0]  base_q, size_q, addr_q;
	logic [DATA_W-1:0]  res_addr_q;
	status_t            res_status_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_addr_q;
	status_t            out_status_q;

	entry_t             mem [MAX_BLOCKS];
	entry_t             rdata_s1;
	logic               rzero_s1;
	entry_t             entry_rd;

	logic [CNT_W-1:0]   rd_addr_c, wa_c;
	logic               we_c;
	entry_t             wd_c;
	logic [DATA_W-1:0]  limit_c;
	calc_t              calc;

	logic               accept, out_free, is_last, full, fit_here;
	logic [CNT_W-1:0]   idx_nx;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign idx_nx   = idx_q + CNT_W'(1);
	assign is_last  = idx_nx == count_q;
	assign full     = count_q == CNT_W'(MAX_BLOCKS);
	assign entry_rd = rzero_s1 ? '0 : rdata_s1;
	assign limit_c  = (state_q == S_ALAST) ? heap_q : entry_rd.start;
	assign fit_here = (idx_q != '0) && calc.fit;

	ffba_unit u_unit (
		.ent       (entry_rd),
		.size      (size_q),
		.addr      (addr_q),
		.limit     (limit_c),
		.base_prev (base_q),
		.need_prev (need_q),
		.calc      (calc)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.operation == OP_ALLOC) begin
						state_nx = full ? S_RESP : S_AWALK;
					end else begin
						state_nx = (count_q == CNT_W'(1)) ? S_RESP : S_FWALK;
					end
				end
			end
			S_AWALK: begin
				if (fit_here) begin
					state_nx = S_ASHIFT;
				end else if (is_last) begin
					state_nx = S_ALAST;
				end
			end
			S_ALAST:  state_nx = calc.fit ? S_APLACE : S_RESP;
			S_ASHIFT: state_nx = (sh_q - CNT_W'(1) == pos_q) ? S_APLACE : S_ASHIFT;
			S_APLACE: state_nx = S_RESP;
			S_FWALK: begin
				if (calc.match) begin
					state_nx = is_last ? S_RESP : S_FSHIFT;
				end else if (is_last) begin
					state_nx = S_RESP;
				end
			end
			S_FSHIFT: state_nx = (sh_q + CNT_W'(2) == count_q) ? S_RESP : S_FSHIFT;
			S_RESP:   state_nx = out_free ? S_IDLE : S_RESP;
			default:  state_nx = S_IDLE;
		endcase
	end

	// table port controls
	always_comb begin
		rd_addr_c = '0;
		we_c      = 1'b0;
		wa_c      = sh_q;
		wd_c      = rdata_s1;
		unique case (state_q)
			S_IDLE:   rd_addr_c = (req.operation == OP_ALLOC) ? '0 : CNT_W'(1);
			S_AWALK:  rd_addr_c = fit_here ? count_q - CNT_W'(1) : idx_nx;
			S_ASHIFT: begin
				we_c      = 1'b1;
				rd_addr_c = sh_q - CNT_W'(2);
			end
			S_APLACE: begin
				we_c = 1'b1;
				wa_c = pos_q;
				wd_c = '{start: base_q, length: size_q};
			end
			S_FWALK:  rd_addr_c = idx_nx;
			S_FSHIFT: begin
				we_c      = 1'b1;
				rd_addr_c = sh_q + CNT_W'(2);
			end
			default:  rd_addr_c = '0;
		endcase
	end

	assign req.ready           = state_q == S_IDLE;
	assign rsp.valid           = out_valid_q;
	assign rsp.granted_address = out_addr_q;
	assign rsp.status          = out_status_q;

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[wa_c[IDX_W-1:0]] <= wd_c;
		end
		rdata_s1 <= mem[rd_addr_c[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			heap_q      <= HEAP_RESET;
			count_q     <= CNT_W'(1);
			out_valid_q <= 1'b0;
			rzero_s1    <= 1'b0;
		end else begin
			state_q  <= state_nx;
			rzero_s1 <= rd_addr_c == '0;
			if (cfg_we) begin
				heap_q <= cfg_wdata;
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_APLACE) begin
				count_q <= count_q + CNT_W'(1);
			end else if ((state_q == S_FWALK && calc.match && is_last)
					|| (state_q == S_FSHIFT && sh_q + CNT_W'(2) == count_q)) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
		unique case (state_q)
			S_IDLE: begin
				size_q       <= req.request_size;
				addr_q       <= req.block_address;
				res_addr_q   <= '0;
				res_status_q <= (req.operation == OP_ALLOC) ? ST_FULL : ST_NOTFOUND;
				idx_q        <= (req.operation == OP_ALLOC) ? '0 : CNT_W'(1);
			end
			S_AWALK: begin
				if (fit_here) begin
					pos_q <= idx_q;
					sh_q  <= count_q;
				end else begin
					need_q <= calc.need;
					base_q <= calc.base;
					idx_q  <= idx_nx;
				end
			end
			S_ALAST: begin
				pos_q        <= count_q;
				res_status_q <= ST_NOSPACE;
			end
			S_ASHIFT: sh_q <= sh_q - CNT_W'(1);
			S_APLACE: begin
				res_addr_q   <= calc.grant;
				res_status_q <= ST_DONE;
			end
			S_FWALK: begin
				sh_q  <= idx_q;
				idx_q <= idx_nx;
				if (calc.match) begin
					res_status_q <= ST_DONE;
				end
			end
			S_FSHIFT: sh_q <= sh_q + CNT_W'(1);
			default: begin
			end
		endcase
	end

endmodule

FILE: sv/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] granted_address,
	input logic [1:0]  status
);
	import ffba_pkg::*;

	property p_rsp_hold;
		@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_address) && $stable(status);
	endproperty
	a_rsp_hold: assert property (p_rsp_hold) else $error("response changed while stalled");

	property p_busy_after_accept;
		@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready;
	endproperty
	a_busy_after_accept: assert property (p_busy_after_accept)
		else $error("request taken while a word is in work");

	property p_fail_zero_addr;
		@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_DONE |-> granted_address == '0;
	endproperty
	a_fail_zero_addr: assert property (p_fail_zero_addr)
		else $error("failed status with nonzero address");

	property p_grant_past_header;
		@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_DONE |->
			granted_address == '0 || granted_address >= 32'(2 * HEADER_BYTES);
	endproperty
	a_grant_past_header: assert property (p_grant_past_header)
		else $error("granted address inside base block header");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.granted_address (rsp.granted_address),
	.status          (rsp.status)
);

FILE: verif/tb_first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_core
// Self-checking bench for the first-fit block allocator. A scoreboard keeps
// its own copy of the block table and heap size, predicts the response word
// of every accepted request and compares it with what the core returns.
// Directed allocate/free cases come first, then random phases at several heap
// sizes with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ffba_pkg::*;

	localparam int PHASE_ITEMS = 258;
	localparam int TAIL_CYCLES = 150;

	typedef struct packed {
		logic [DATA_W-1:0] addr;
		status_t           st;
	} alloc_result_t;

	class alloc_scoreboard;
		logic [DATA_W-1:0] heap_size;
		logic [DATA_W-1:0] start_tab [MAX_BLOCKS];
		logic [DATA_W-1:0] len_tab [MAX_BLOCKS];
		int                count;
		alloc_result_t     pending_results [$];
		int                errors;

		function new();
			heap_size = HEAP_RESET;
			foreach (start_tab[k]) begin
				start_tab[k] = '0;
				len_tab[k]   = '0;
			end
			count  = 1;
			errors = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_request(logic op, logic [DATA_W-1:0] size,
				logic [DATA_W-1:0] uaddr);
			logic [63:0]   need;
			logic [63:0]   lim;
			logic [63:0]   base;
			int            pos;
			int            i;
			alloc_result_t res;
			res.addr = '0;
			if (op == OP_ALLOC) begin
				if (count >= MAX_BLOCKS) begin
					res.st = ST_FULL;
				end else begin
					res.st = ST_NOSPACE;
					pos = -1;
					for (i = 0; i < count && pos < 0; i++) begin
						need = 64'(start_tab[i]) + 64'(2 * HEADER_BYTES) + 64'(len_tab[i])
							+ 64'(size);
						lim = (i == count - 1) ? 64'(heap_size) : 64'(start_tab[i + 1]);
						if (need < lim)
							pos = i + 1;
					end
					if (pos > 0) begin
						base = 64'(start_tab[pos - 1]) + 64'(HEADER_BYTES)
							+ 64'(len_tab[pos - 1]);
						for (i = count; i > pos; i--) begin
							start_tab[i] = start_tab[i - 1];
							len_tab[i]   = len_tab[i - 1];
						end
						start_tab[pos] = base[DATA_W-1:0];
						len_tab[pos]   = size;
						count++;
						res.addr = DATA_W'(base + 64'(HEADER_BYTES));
						res.st   = ST_DONE;
					end
				end
			end else begin
				res.st = ST_NOTFOUND;
				pos = -1;
				for (i = 1; i < count && pos < 0; i++)
					if (64'(start_tab[i]) + 64'(HEADER_BYTES) == 64'(uaddr))
						pos = i;
				if (pos > 0) begin
					for (i = pos; i < count - 1; i++) begin
						start_tab[i] = start_tab[i + 1];
						len_tab[i]   = len_tab[i + 1];
					end
					count--;
					res.st = ST_DONE;
				end
			end
			pending_results.push_back(res);
		endfunction

		task report_mismatch(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_response(logic [DATA_W-1:0] addr, logic [1:0] st);
			alloc_result_t exp;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("response word addr %0h status %0d with none due",
					addr, st));
			end else begin
				exp = pending_results.pop_front();
				if (addr !== exp.addr)
					report_mismatch($sformatf("granted_address %0h, predicted %0h",
						addr, exp.addr));
				if (st !== exp.st)
					report_mismatch($sformatf("status %0d, predicted %0d", st, exp.st));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [DATA_W-1:0] cfg_wdata;

	ffba_req_if req_ch ();
	ffba_rsp_if rsp_ch ();

	alloc_scoreboard sb = new();

	int burst_left;
	int stall_mode;
	int mode_left;
	int cyc;

	first_fit_block_allocator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// response side: check accepted words, stall in changing modes
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.granted_address, rsp_ch.status);
		cyc <= cyc + 1;
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(3);
			mode_left  <= $urandom_range(300, 40);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= ($urandom_range(3) != 0);
			2: rsp_ch.ready <= ($urandom_range(3) == 0);
			default: rsp_ch.ready <= ((cyc % 7) > 2);
		endcase
	end

	task automatic issue_word(logic op, logic [DATA_W-1:0] size, logic [DATA_W-1:0] uaddr);
		req_ch.valid         <= 1'b1;
		req_ch.operation     <= op;
		req_ch.request_size  <= size;
		req_ch.block_address <= uaddr;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(op, size, uaddr);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(20, 1))
				@(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(6);
		end
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic set_heap(logic [DATA_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.heap_size = value;
	endtask

	initial begin
		int                ph;
		int                alloc_pct;
		int                size_cap;
		int                r;
		int                k;
		int                last;
		longint            tail;
		logic [DATA_W-1:0] heap;
		logic [DATA_W-1:0] size;
		logic [DATA_W-1:0] uaddr;

		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		req_ch.valid         <= 1'b0;
		req_ch.operation     <= OP_ALLOC;
		req_ch.request_size  <= '0;
		req_ch.block_address <= '0;
		burst_left = 0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// base block and unmatched frees
		issue_word(OP_FREE, 32'hFFFF_FFFF, 32'(HEADER_BYTES));
		issue_word(OP_FREE, 32'h0, 32'h0);
		issue_word(OP_FREE, 32'h1234, 32'hFFFF_FFFF);
		// build three blocks, then free the middle one and refill its gap
		issue_word(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
		issue_word(OP_ALLOC, 32'd100, 32'h0);
		issue_word(OP_ALLOC, 32'd50, 32'h5A5A_5A5A);
		issue_word(OP_FREE, 32'h0, 32'd48);
		issue_word(OP_ALLOC, 32'd20, 32'h0);
		issue_word(OP_FREE, 32'h0, 32'd49);
		issue_word(OP_ALLOC, 32'hFFFF_FFFF, 32'h0);
		// exact fit against the heap end fails, one byte less fits
		drain_results();
		last = sb.count - 1;
		tail = longint'(sb.heap_size) - longint'(sb.start_tab[last]) - 2 * HEADER_BYTES
			- longint'(sb.len_tab[last]);
		issue_word(OP_ALLOC, 32'(tail), 32'h0);
		issue_word(OP_ALLOC, 32'(tail - 1), 32'h0);
		issue_word(OP_ALLOC, 32'd0, 32'h0);
		// zero heap: only the gaps between blocks can take a block
		set_heap(32'h0);
		issue_word(OP_ALLOC, 32'd0, 32'h0);
		issue_word(OP_ALLOC, 32'd8, 32'h0);
		issue_word(OP_ALLOC, 32'd1000, 32'h0);
		// full-range heap
		set_heap(32'hFFFF_FFFF);
		issue_word(OP_ALLOC, 32'hFFFF_FFFF, 32'h0);
		issue_word(OP_ALLOC, 32'h7FFF_0000, 32'h0);
		issue_word(OP_ALLOC, 32'h8000_0000, 32'h0);
		issue_word(OP_FREE, 32'h0, 32'd32);
		issue_word(OP_FREE, 32'h0, 32'd32);

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin heap = 32'hFFFF_FFFF; alloc_pct = 85; size_cap = 1 << 20; end
				1: begin heap = HEAP_RESET; alloc_pct = 55; size_cap = 1500; end
				2: begin heap = 32'h0; alloc_pct = 50; size_cap = 64; end
				3: begin heap = 32'd4096; alloc_pct = 60; size_cap = 200; end
				4: begin heap = $urandom; alloc_pct = 55; size_cap = 1 << 16; end
				default: begin heap = HEAP_RESET; alloc_pct = 45; size_cap = 3000; end
			endcase
			set_heap(heap);
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(99);
				uaddr = $urandom;
				size = $urandom;
				if (r < alloc_pct) begin
					r = $urandom_range(99);
					last = sb.count - 1;
					tail = longint'(sb.heap_size) - longint'(sb.start_tab[last])
						- 2 * HEADER_BYTES - longint'(sb.len_tab[last]);
					if (r < 85)
						size = $urandom_range(size_cap);
					else if (r < 92 && tail > 0)
						size = 32'(tail - longint'($urandom_range(1)));
					else if (r < 96)
						size = $urandom_range(3);
					issue_word(OP_ALLOC, size, uaddr);
				end else begin
					r = $urandom_range(99);
					if (r < 80 && sb.count > 1) begin
						k = $urandom_range(sb.count - 1, 1);
						uaddr = sb.start_tab[k] + HEADER_BYTES;
					end else if (r < 90 && sb.count > 1) begin
						k = $urandom_range(sb.count - 1, 1);
						uaddr = sb.start_tab[k] + HEADER_BYTES + ($urandom_range(1) ? 1 : -1);
					end else if (r < 95) begin
						uaddr = HEADER_BYTES;
					end
					issue_word(OP_FREE, size, uaddr);
				end
				if ($urandom_range(149) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d predicted words never came", sb.pending()));
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/ffba_pkg.sv
sv/ffba_if.sv
sv/ffba_unit.sv
sv/first_fit_block_allocator_core.sv
sv/ffba_checker.sv
verif/tb_first_fit_block_allocator_core.sv
